[rtl/traffic_light_controller_unit_macros.svh]
// Assertion helpers for the controller RTL.
`ifndef TRAFFIC_LIGHT_CONTROLLER_UNIT_MACROS_SVH
`define TRAFFIC_LIGHT_CONTROLLER_UNIT_MACROS_SVH

// Generic clocked assertion with an explicit clock and active-low reset.
`define TLC_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Same, on the block clock and reset.
`define TLC_ASSERT(lbl, prop, msg) \
  `TLC_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

[rtl/tlc_pkg.sv]
`timescale 1ns / 1ps

package tlc_pkg;

  // Timing constants, in ticks of one millisecond
  localparam int unsigned SAMPLE_PERIOD_MS = 50;
  localparam int unsigned SECOND_MS        = 1000;

  localparam int DUR_W   = 16;
  localparam int LIGHT_W = 12;
  localparam int TIME_W  = 32;
  localparam int CNT_W   = 8;

  // Register reset values
  localparam logic [DUR_W-1:0]   RED_TIME_RST    = DUR_W'(5000);
  localparam logic [DUR_W-1:0]   GREEN_TIME_RST  = DUR_W'(10000);
  localparam logic [DUR_W-1:0]   YELLOW_TIME_RST = DUR_W'(3000);
  localparam logic [LIGHT_W-1:0] DARK_THR_RST    = LIGHT_W'(1000);

  // Register indexes on the config port
  localparam logic [1:0] REG_RED_TIME    = 2'd0;
  localparam logic [1:0] REG_GREEN_TIME  = 2'd1;
  localparam logic [1:0] REG_YELLOW_TIME = 2'd2;
  localparam logic [1:0] REG_DARK_THR    = 2'd3;

  // Lamp bit positions
  localparam int LAMP_RED    = 0;
  localparam int LAMP_YELLOW = 1;
  localparam int LAMP_GREEN  = 2;
  localparam int LAMP_IND    = 3;

  // Input word kinds carried on tuser
  localparam logic ACT_TICK   = 1'b0;
  localparam logic ACT_REMOTE = 1'b1;

  // Reciprocal for dividing a duration by SECOND_MS: floor(d / S) equals
  // (d * ceil(2^30 / S)) >> 30 for every 16-bit d and S up to 10000.
  localparam int RECIP_SHIFT = 30;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int PROD_W      = DUR_W + RECIP_W;
  localparam logic [RECIP_W-1:0] SEC_RECIP =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(SECOND_MS) - 64'd1) / 64'(SECOND_MS));

  // Countdown start value: whole seconds of a duration, minus one, 8-bit wrap
  function automatic logic [CNT_W-1:0] load_count(input logic [DUR_W-1:0] dur);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(dur) * PROD_W'(SEC_RECIP);
    return prod[RECIP_SHIFT +: CNT_W] - CNT_W'(1);
  endfunction

  localparam logic [CNT_W-1:0] SHOWN_RST = load_count(RED_TIME_RST);
  localparam logic [CNT_W-1:0] COUNT_RST = SHOWN_RST - CNT_W'(1);

endpackage

[rtl/traffic_light_controller_unit.sv]
`timescale 1ns / 1ps

// Channel   Dir  Word layout (low bit first)
// s_axis    in   tdata: light_sample[11:0], button_level[12], remote_enable[13], 0[15:14]
//                tuser: action (0 tick, 1 remote enable write)
// m_axis    out  tdata: red, yellow, green, indicator, display_blank, display_number[12:5],
//                display_update[13], dark_mode[14], uptime_seconds[46:15], 0[47]
// cfg       in   write enable, 2-bit register index, 16-bit data
//
// One word per cycle while ready is high; its result is registered in the next cycle.
// All per-word work (timers, samplers, sequencer, countdown load) sits between the
// state registers and the output register; the countdown load uses one 16x31 multiply.
// Input ready stays high while the output register is empty or being drained.
// rst_ni clears all state to the power-up phase (red, enabled, indicator lit).

`include "traffic_light_controller_unit_macros.svh"

module traffic_light_controller_unit
  import tlc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // light_sample, button_level, remote_enable
  input  logic        s_axis_tuser,  // action
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // lamps r/y/g/ind, blank, number, update, dark, uptime
  // config writes
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  typedef enum logic [1:0] {
    PH_RED    = 2'd0,
    PH_GREEN  = 2'd1,
    PH_YELLOW = 2'd2
  } phase_e;

  // config registers
  logic [DUR_W-1:0]   red_time_q, green_time_q, yellow_time_q;
  logic [LIGHT_W-1:0] dark_thr_q;

  // state
  logic [TIME_W-1:0]  time_now_q, phase_start_q, count_start_q, light_start_q;
  logic [TIME_W-1:0]  blink_start_q, button_start_q, uptime_start_q, uptime_q;
  phase_e             phase_q;
  logic [CNT_W-1:0]   countdown_q, shown_q;
  logic               cleared_q, dark_q, blink_on_q, last_button_q, enabled_q;
  logic [LIGHT_W-1:0] last_light_q;
  logic [3:0]         lamp_q;

  logic [TIME_W-1:0]  time_now_d, phase_start_d, count_start_d, light_start_d;
  logic [TIME_W-1:0]  blink_start_d, button_start_d, uptime_start_d, uptime_d;
  phase_e             phase_d;
  logic [CNT_W-1:0]   countdown_d, shown_d;
  logic               cleared_d, dark_d, blink_on_d, last_button_d, enabled_d;
  logic [LIGHT_W-1:0] last_light_d;
  logic [3:0]         lamp_d;
  logic               update_d;

  // output register
  logic        m_valid_q;
  logic [47:0] m_data_q;
  logic [47:0] m_data_d;

  logic s_accept;

  // input fields
  logic [LIGHT_W-1:0] in_light;
  logic               in_button, in_remote;

  assign in_light  = s_axis_tdata[11:0];
  assign in_button = s_axis_tdata[12];
  assign in_remote = s_axis_tdata[13];

  assign s_axis_tready = !m_valid_q || m_axis_tready;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  function automatic logic [3:0] phase_lamp(input phase_e p);
    logic [3:0] l;
    l = '0;
    unique case (p)
      PH_RED:    l[LAMP_RED]    = 1'b1;
      PH_GREEN:  l[LAMP_GREEN]  = 1'b1;
      PH_YELLOW: l[LAMP_YELLOW] = 1'b1;
      default:   l = '0;
    endcase
    return l;
  endfunction

  function automatic logic elapsed(input logic [TIME_W-1:0] now,
                                   input logic [TIME_W-1:0] start,
                                   input logic [TIME_W-1:0] period);
    logic [TIME_W-1:0] diff;
    diff = now - start;
    return diff >= period;
  endfunction

  // next phase and its countdown load, independent of the timer compare
  phase_e           next_phase;
  logic [DUR_W-1:0] cur_dur, next_dur;
  logic             phase_valid;
  logic [CNT_W-1:0] next_load;

  always_comb begin
    phase_valid = 1'b1;
    unique case (phase_q)
      PH_RED: begin
        cur_dur = red_time_q; next_phase = PH_GREEN; next_dur = green_time_q;
      end
      PH_GREEN: begin
        cur_dur = green_time_q; next_phase = PH_YELLOW; next_dur = yellow_time_q;
      end
      PH_YELLOW: begin
        cur_dur = yellow_time_q; next_phase = PH_RED; next_dur = red_time_q;
      end
      default: begin
        cur_dur = '0; next_phase = phase_q; next_dur = '0; phase_valid = 1'b0;
      end
    endcase
  end

  assign next_load = load_count(next_dur);

  // per-word state update
  always_comb begin
    logic               show;
    logic [TIME_W-1:0]  t;
    time_now_d     = time_now_q;
    phase_start_d  = phase_start_q;
    count_start_d  = count_start_q;
    light_start_d  = light_start_q;
    blink_start_d  = blink_start_q;
    button_start_d = button_start_q;
    uptime_start_d = uptime_start_q;
    uptime_d       = uptime_q;
    phase_d        = phase_q;
    countdown_d    = countdown_q;
    shown_d        = shown_q;
    cleared_d      = cleared_q;
    dark_d         = dark_q;
    blink_on_d     = blink_on_q;
    last_button_d  = last_button_q;
    enabled_d      = enabled_q;
    last_light_d   = last_light_q;
    lamp_d         = lamp_q;
    update_d       = 1'b0;
    show           = 1'b0;
    t              = time_now_q + TIME_W'(1);

    if (s_axis_tuser == ACT_REMOTE) begin
      enabled_d = in_remote;
      if (in_remote) begin
        lamp_d[LAMP_IND] = 1'b1;
      end else begin
        lamp_d    = '0;
        cleared_d = 1'b1;
      end
    end else begin
      time_now_d = t;

      // uptime seconds
      if (elapsed(t, uptime_start_q, TIME_W'(SECOND_MS))) begin
        uptime_start_d = t;
        if (enabled_q) uptime_d = uptime_q + TIME_W'(1);
      end

      // button sampler, toggle on release
      if (elapsed(t, button_start_q, TIME_W'(SAMPLE_PERIOD_MS))) begin
        button_start_d = t;
        if (in_button != last_button_q) begin
          last_button_d = in_button;
          if (in_button) begin
            enabled_d = !enabled_q;
            if (!enabled_q) begin
              lamp_d = lamp_d | phase_lamp(phase_q);
              lamp_d[LAMP_IND] = 1'b1;
            end else begin
              lamp_d    = '0;
              cleared_d = 1'b1;
            end
          end
        end
      end

      // light sampler
      if (elapsed(t, light_start_q, TIME_W'(SAMPLE_PERIOD_MS))) begin
        light_start_d = t;
        if (in_light != last_light_q) begin
          if (in_light < dark_thr_q) begin
            if (!dark_q && enabled_d) lamp_d = lamp_d & ~phase_lamp(phase_q);
            dark_d = enabled_d;
          end else begin
            if (dark_q) lamp_d[LAMP_YELLOW] = 1'b0;
            dark_d = 1'b0;
          end
          last_light_d = in_light;
        end
      end

      if (dark_d) begin
        // night blink
        if (enabled_d && elapsed(t, blink_start_q, TIME_W'(SECOND_MS))) begin
          blink_start_d       = t;
          lamp_d[LAMP_YELLOW] = !blink_on_q;
          blink_on_d          = !blink_on_q;
        end
      end else if (enabled_d) begin
        // phase sequencer and countdown
        if (phase_valid && elapsed(t, phase_start_q, TIME_W'(cur_dur))) begin
          phase_start_d = t;
          lamp_d        = (lamp_d & ~phase_lamp(phase_q)) | phase_lamp(next_phase);
          phase_d       = next_phase;
          count_start_d = t;
          show          = 1'b1;
          shown_d       = next_load;
        end else if (elapsed(t, count_start_q, TIME_W'(SECOND_MS))) begin
          count_start_d = t;
          show          = 1'b1;
          shown_d       = countdown_q;
        end
        if (show) begin
          countdown_d = shown_d - CNT_W'(1);
          cleared_d   = 1'b0;
        end
        update_d = show;
      end
    end
  end

  // result word
  always_comb begin
    m_data_d        = '0;
    m_data_d[3:0]   = lamp_d;
    m_data_d[4]     = cleared_d;
    m_data_d[12:5]  = cleared_d ? '0 : shown_d;
    m_data_d[13]    = update_d;
    m_data_d[14]    = dark_d;
    m_data_d[46:15] = uptime_d;
  end

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_time_q    <= RED_TIME_RST;
      green_time_q  <= GREEN_TIME_RST;
      yellow_time_q <= YELLOW_TIME_RST;
      dark_thr_q    <= DARK_THR_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_RED_TIME:    red_time_q    <= cfg_data_i;
        REG_GREEN_TIME:  green_time_q  <= cfg_data_i;
        REG_YELLOW_TIME: yellow_time_q <= cfg_data_i;
        REG_DARK_THR:    dark_thr_q    <= cfg_data_i[LIGHT_W-1:0];
        default:         dark_thr_q    <= dark_thr_q;
      endcase
    end
  end

  // state registers, updated on each accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_now_q     <= '0;
      phase_start_q  <= '0;
      count_start_q  <= '0;
      light_start_q  <= '0;
      blink_start_q  <= '0;
      button_start_q <= '0;
      uptime_start_q <= '0;
      uptime_q       <= '0;
      phase_q        <= PH_RED;
      countdown_q    <= COUNT_RST;
      shown_q        <= SHOWN_RST;
      cleared_q      <= 1'b0;
      dark_q         <= 1'b0;
      blink_on_q     <= 1'b0;
      last_button_q  <= 1'b1;
      enabled_q      <= 1'b1;
      last_light_q   <= '0;
      lamp_q         <= 4'b1001;
    end else if (s_accept) begin
      time_now_q     <= time_now_d;
      phase_start_q  <= phase_start_d;
      count_start_q  <= count_start_d;
      light_start_q  <= light_start_d;
      blink_start_q  <= blink_start_d;
      button_start_q <= button_start_d;
      uptime_start_q <= uptime_start_d;
      uptime_q       <= uptime_d;
      phase_q        <= phase_d;
      countdown_q    <= countdown_d;
      shown_q        <= shown_d;
      cleared_q      <= cleared_d;
      dark_q         <= dark_d;
      blink_on_q     <= blink_on_d;
      last_button_q  <= last_button_d;
      enabled_q      <= enabled_d;
      last_light_q   <= last_light_d;
      lamp_q         <= lamp_d;
    end
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (s_accept) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      m_data_q <= m_data_d;
    end
  end

  `TLC_ASSERT(a_off_lamps_dark, !enabled_q |-> (lamp_q == 4'b0000), "lamps lit while disabled")
  `TLC_ASSERT(a_on_indicator, enabled_q |-> lamp_q[LAMP_IND], "indicator off while enabled")
  `TLC_ASSERT(a_red_green_excl, $onehot0({lamp_q[LAMP_RED], lamp_q[LAMP_GREEN]}), "red and green both lit")
  `TLC_ASSERT(a_accept_to_out, s_accept |=> m_valid_q, "accepted word produced no result")

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps

module tb;
  import tlc_pkg::*;

  localparam int IDLE_LIMIT = 2000;

  localparam logic [3:0] RED_BIT    = 4'(1 << LAMP_RED);
  localparam logic [3:0] YELLOW_BIT = 4'(1 << LAMP_YELLOW);
  localparam logic [3:0] GREEN_BIT  = 4'(1 << LAMP_GREEN);
  localparam logic [3:0] IND_BIT    = 4'(1 << LAMP_IND);

  typedef enum logic [1:0] {
    PH_RED    = 2'd0,
    PH_GREEN  = 2'd1,
    PH_YELLOW = 2'd2
  } phase_e;

  // Result word, laid out as on m_axis_tdata (lamps in the low nibble)
  typedef struct packed {
    logic        pad;
    logic [31:0] uptime;
    logic        dark;
    logic        update;
    logic [7:0]  number;
    logic        blank;
    logic [3:0]  lamps;
  } light_word_t;

  typedef struct packed {
    logic        act;
    logic [15:0] data;
    logic        typed;
    light_word_t want;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // light_sample, button_level, remote_enable
  logic        s_axis_tuser;   // action
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;   // lamps r/y/g/ind, blank, number, update, dark, uptime
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;

  traffic_light_controller_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Controller model state
  logic [15:0] red_ms, green_ms, yellow_ms;
  logic [11:0] dark_thr;
  logic [31:0] now_ms, phase_t0, count_t0, light_t0, blink_t0, button_t0, up_t0, up_secs;
  phase_e      cur_phase;
  logic [7:0]  count_q, shown_q;
  logic [11:0] light_q;
  logic [3:0]  lamps_q;
  logic        blank_q, dark_q, blink_q, btn_q, en_q;

  light_word_t lamp_words_due [$];
  stim_row_t   directed_rows [$];
  light_word_t seen_word;
  int          errors = 0;
  int          idle_cycles = 0;
  int          burst_left = 0;
  int          stall_mode = 0;
  int          stall_cnt = 0;
  logic [11:0] level_now = 12'd0;
  logic        btn_now = 1'b1;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [3:0] phase_mask(input phase_e p);
    case (p)
      PH_RED:    return RED_BIT;
      PH_GREEN:  return GREEN_BIT;
      PH_YELLOW: return YELLOW_BIT;
      default:   return 4'd0;
    endcase
  endfunction

  function automatic logic [15:0] duration_of(input phase_e p);
    case (p)
      PH_RED:    return red_ms;
      PH_GREEN:  return green_ms;
      PH_YELLOW: return yellow_ms;
      default:   return 16'd0;
    endcase
  endfunction

  // Result with no update, no dark mode and zero uptime
  function automatic light_word_t idle_word(input logic [3:0] lamps, input logic blank,
                                            input logic [7:0] number);
    light_word_t w;
    w = '0;
    w.lamps = lamps;
    w.blank = blank;
    w.number = number;
    return w;
  endfunction

  task automatic reset_controller();
    red_ms    = RED_TIME_RST;
    green_ms  = GREEN_TIME_RST;
    yellow_ms = YELLOW_TIME_RST;
    dark_thr  = DARK_THR_RST;
    now_ms = '0; phase_t0 = '0; count_t0 = '0; light_t0 = '0;
    blink_t0 = '0; button_t0 = '0; up_t0 = '0; up_secs = '0;
    cur_phase = PH_RED;
    shown_q = 8'(32'(RED_TIME_RST) / SECOND_MS - 32'd1);
    count_q = shown_q - 8'd1;
    light_q = '0;
    lamps_q = RED_BIT | IND_BIT;
    blank_q = 1'b0; dark_q = 1'b0; blink_q = 1'b0;
    btn_q = 1'b1; en_q = 1'b1;
  endtask

  // Advance the controller by one input word and form its result
  task automatic step_controller(input logic act, input logic [15:0] data,
                                 output light_word_t res);
    logic [11:0] light;
    logic        btn;
    logic        show;
    phase_e      nxt;
    light = data[11:0];
    btn = data[12];
    show = 1'b0;
    if (act == ACT_REMOTE) begin
      en_q = data[13];
      if (en_q) begin
        lamps_q = lamps_q | IND_BIT;
      end else begin
        lamps_q = '0;
        blank_q = 1'b1;
      end
    end else begin
      now_ms = now_ms + 32'd1;

      // uptime, counted only while enabled
      if (now_ms - up_t0 >= 32'(SECOND_MS)) begin
        up_t0 = now_ms;
        if (en_q) up_secs = up_secs + 32'd1;
      end

      // button: a release edge toggles enable
      if (now_ms - button_t0 >= 32'(SAMPLE_PERIOD_MS)) begin
        button_t0 = now_ms;
        if (btn != btn_q) begin
          btn_q = btn;
          if (btn) begin
            en_q = !en_q;
            if (en_q) begin
              lamps_q = lamps_q | IND_BIT | phase_mask(cur_phase);
            end else begin
              lamps_q = '0;
              blank_q = 1'b1;
            end
          end
        end
      end

      // light: only a changed sample counts
      if (now_ms - light_t0 >= 32'(SAMPLE_PERIOD_MS)) begin
        light_t0 = now_ms;
        if (light != light_q) begin
          if (light < dark_thr) begin
            if (!dark_q && en_q) lamps_q = lamps_q & ~phase_mask(cur_phase);
            dark_q = en_q;
          end else begin
            if (dark_q) lamps_q[LAMP_YELLOW] = 1'b0;
            dark_q = 1'b0;
          end
          light_q = light;
        end
      end

      if (dark_q) begin
        // night blink, frozen while disabled
        if (en_q && (now_ms - blink_t0 >= 32'(SECOND_MS))) begin
          blink_t0 = now_ms;
          blink_q = !blink_q;
          lamps_q[LAMP_YELLOW] = blink_q;
        end
      end else if (en_q) begin
        // phase sequencer and countdown
        case (cur_phase)
          PH_RED:    nxt = PH_GREEN;
          PH_GREEN:  nxt = PH_YELLOW;
          PH_YELLOW: nxt = PH_RED;
          default:   nxt = cur_phase;
        endcase
        if (nxt != cur_phase && (now_ms - phase_t0 >= 32'(duration_of(cur_phase)))) begin
          phase_t0 = now_ms;
          lamps_q = (lamps_q & ~phase_mask(cur_phase)) | phase_mask(nxt);
          cur_phase = nxt;
          count_q = 8'(32'(duration_of(nxt)) / SECOND_MS - 32'd1);
          count_t0 = now_ms;
          show = 1'b1;
        end
        if (!show && (now_ms - count_t0 >= 32'(SECOND_MS))) begin
          count_t0 = now_ms;
          show = 1'b1;
        end
        if (show) begin
          shown_q = count_q;
          count_q = count_q - 8'd1;
          blank_q = 1'b0;
        end
      end
    end
    res = '0;
    res.lamps = lamps_q;
    res.blank = blank_q;
    res.number = blank_q ? 8'd0 : shown_q;
    res.update = show;
    res.dark = dark_q;
    res.uptime = up_secs;
  endtask

  task automatic add_row(input logic act, input logic [11:0] light, input logic btn,
                         input logic ren, input logic typed, input light_word_t want);
    stim_row_t r;
    r.act = act;
    r.data = {2'b00, ren, btn, light};
    r.typed = typed;
    r.want = want;
    directed_rows.push_back(r);
  endtask

  // Send one word in bursts with random gaps, then queue its expected result
  task automatic push_word(input logic act, input logic [15:0] data, input logic typed,
                           input light_word_t want);
    int          gap;
    light_word_t predicted;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 7);
    end
    burst_left--;
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= act;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    step_controller(act, data, predicted);
    lamp_words_due.push_back(typed ? want : predicted);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      REG_RED_TIME:    red_ms = val;
      REG_GREEN_TIME:  green_ms = val;
      REG_YELLOW_TIME: yellow_ms = val;
      REG_DARK_THR:    dark_thr = val[11:0];
      default: ;
    endcase
  endtask

  // Registers change only with the block drained
  task automatic apply_setting(input logic [15:0] red, input logic [15:0] green,
                               input logic [15:0] yellow, input logic [11:0] thr);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (lamp_words_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    write_reg(REG_RED_TIME, red);
    write_reg(REG_GREEN_TIME, green);
    write_reg(REG_YELLOW_TIME, yellow);
    write_reg(REG_DARK_THR, {4'd0, thr});
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // New light level: anywhere, an extreme, around the threshold, or below it
  function automatic logic [11:0] pick_light();
    int v;
    case ($urandom_range(0, 3))
      0:       v = $urandom_range(0, 4095);
      1:       v = ($urandom_range(0, 1) != 0) ? 4095 : 0;
      2:       v = int'(dark_thr) + int'($urandom_range(0, 2)) - 1;
      default: v = (dark_thr > 0) ? int'($urandom_range(0, int'(dark_thr) - 1)) : 0;
    endcase
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return 12'(v);
  endfunction

  // Mostly ticks with slowly changing light and button, some remote writes
  task automatic run_random(input int n_words);
    logic [11:0] light;
    logic        btn;
    logic [15:0] data;
    for (int k = 0; k < n_words; k++) begin
      if ($urandom_range(0, 39) == 0) begin
        data = 16'($urandom) & 16'h3fff;
        data[13] = ($urandom_range(0, 3) != 0);
        push_word(ACT_REMOTE, data, 1'b0, '0);
      end else begin
        if ($urandom_range(0, 39) == 0) level_now = pick_light();
        if ($urandom_range(0, 89) == 0) btn_now = !btn_now;
        light = level_now;
        btn = btn_now;
        if ($urandom_range(0, 59) == 0) btn = !btn;
        if ($urandom_range(0, 49) == 0) light = 12'($urandom);
        data = {2'b00, 1'($urandom), btn, light};
        push_word(ACT_TICK, data, 1'b0, '0);
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      errors++;
    end
  endtask

  task automatic check_lamp_word(input light_word_t want, input light_word_t got);
    string lamp_name [4];
    lamp_name[LAMP_RED]    = "red_lamp";
    lamp_name[LAMP_YELLOW] = "yellow_lamp";
    lamp_name[LAMP_GREEN]  = "green_lamp";
    lamp_name[LAMP_IND]    = "indicator_lamp";
    for (int i = 0; i < 4; i++) check_field(lamp_name[i], 32'(want.lamps[i]), 32'(got.lamps[i]));
    check_field("display_blank", 32'(want.blank), 32'(got.blank));
    check_field("display_number", 32'(want.number), 32'(got.number));
    check_field("display_update", 32'(want.update), 32'(got.update));
    check_field("dark_mode", 32'(want.dark), 32'(got.dark));
    check_field("uptime_seconds", want.uptime, got.uptime);
    check_field("tdata_pad", 32'(want.pad), 32'(got.pad));
  endtask

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (lamp_words_due.size() == 0) begin
        $error("result word with no expected word pending: 0x%0h", m_axis_tdata);
        errors++;
      end else begin
        seen_word = lamp_words_due.pop_front();
        check_lamp_word(seen_word, light_word_t'(m_axis_tdata));
      end
    end
  end

  // Receiver back pressure: always, mostly, periodically or rarely ready
  always @(negedge clk_i) begin
    if (stall_cnt == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_cnt = $urandom_range(20, 200);
    end
    stall_cnt--;
    case (stall_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= ($urandom_range(0, 2) != 0);
      2:       m_axis_tready <= ((stall_cnt % 5) != 0);
      default: m_axis_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Watchdog on cycles with no word moving on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("traffic_light_controller_unit test failed");
          $finish;
        end
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = ACT_TICK;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_RED_TIME;
    cfg_data_i    = '0;
    reset_controller();

    // Power-up phase, remote enable writes, field extremes
    add_row(ACT_TICK,   12'd0,    1'b1, 1'b0, 1'b1, idle_word(RED_BIT | IND_BIT, 1'b0, 8'd4));
    add_row(ACT_TICK,   12'd4095, 1'b0, 1'b1, 1'b1, idle_word(RED_BIT | IND_BIT, 1'b0, 8'd4));
    add_row(ACT_REMOTE, 12'd4095, 1'b1, 1'b1, 1'b1, idle_word(RED_BIT | IND_BIT, 1'b0, 8'd4));
    add_row(ACT_REMOTE, 12'd0,    1'b0, 1'b0, 1'b1, idle_word(4'd0, 1'b1, 8'd0));
    add_row(ACT_TICK,   12'd0,    1'b1, 1'b1, 1'b1, idle_word(4'd0, 1'b1, 8'd0));
    // enabling remotely lights only the indicator, display stays blank
    add_row(ACT_REMOTE, 12'hfff,  1'b1, 1'b1, 1'b1, idle_word(IND_BIT, 1'b1, 8'd0));
    add_row(ACT_TICK,   12'd4095, 1'b0, 1'b0, 1'b1, idle_word(IND_BIT, 1'b1, 8'd0));
    add_row(ACT_TICK,   12'h800,  1'b1, 1'b1, 1'b1, idle_word(IND_BIT, 1'b1, 8'd0));
    add_row(ACT_TICK,   12'h555,  1'b0, 1'b0, 1'b0, '0);
    add_row(ACT_TICK,   12'haaa,  1'b1, 1'b1, 1'b0, '0);
    add_row(ACT_REMOTE, 12'h3e7,  1'b0, 1'b0, 1'b0, '0);
    add_row(ACT_TICK,   12'h3e8,  1'b1, 1'b0, 1'b0, '0);
    add_row(ACT_REMOTE, 12'd0,    1'b1, 1'b1, 1'b0, '0);
    add_row(ACT_TICK,   12'h001,  1'b0, 1'b1, 1'b0, '0);
    add_row(ACT_TICK,   12'hffe,  1'b1, 1'b0, 1'b0, '0);

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      push_word(directed_rows[i].act, directed_rows[i].data, directed_rows[i].typed,
                directed_rows[i].want);
    end

    // one-second phases, everything but full scale is dark
    apply_setting(16'd1000, 16'd1000, 16'd1000, 12'd4095);
    run_random(470);
    // sub-second phases: fast stepping and countdown wrap
    apply_setting(16'd7, 16'd1, 16'd120, 12'd2048);
    run_random(480);
    // long red and yellow phases, never dark
    apply_setting(16'd60000, 16'd1999, 16'd60000, 12'd0);
    run_random(470);
    apply_setting(16'd1500, 16'd0, 16'd65535, 12'd700);
    run_random(480);

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (lamp_words_due.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("traffic_light_controller_unit test passed");
    end else begin
      $display("traffic_light_controller_unit test failed");
    end
    $finish;
  end

endmodule
